// ===== design/bdhr_pkg.sv =====
// ---------------------------------------------------------------------------
// bdhr_pkg: shared types and constants for the button debounce block
// Register map, phase and counter command codes, control/status bundles.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bdhr_pkg;

  // Tick counter width and register widths
  localparam int CNT_W  = 16;
  localparam int REG_W  = 16;
  localparam int CONF_W = 8;
  localparam int CMP_W  = (CNT_W > REG_W) ? CNT_W : REG_W;
  localparam int TR_W   = CMP_W + 1;
  localparam int ITER_W = $clog2(CNT_W + 1);

  // APB port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_CONFIRM = 3'd0;
  localparam logic [2:0] REG_HOLD    = 3'd1;
  localparam logic [2:0] REG_REPEAT  = 3'd2;
  localparam logic [2:0] REG_LONG    = 3'd3;
  localparam logic [2:0] REG_LOCK    = 3'd4;

  // Register reset values
  localparam logic [CONF_W-1:0] RST_CONFIRM = CONF_W'(7);
  localparam logic [REG_W-1:0]  RST_HOLD    = REG_W'(300);
  localparam logic [REG_W-1:0]  RST_REPEAT  = REG_W'(65);
  localparam logic [REG_W-1:0]  RST_LONG    = REG_W'(2000);
  localparam logic [REG_W-1:0]  RST_LOCK    = REG_W'(30);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PUSHED   = 2'd1,
    PH_RELEASED = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    CNT_KEEP = 2'd0,
    CNT_UP   = 2'd1,
    CNT_DOWN = 2'd2,
    CNT_CLR  = 2'd3
  } cnt_op_t;

  typedef struct packed {
    logic [CONF_W-1:0] confirm;
    logic [REG_W-1:0]  hold_time;
    logic [REG_W-1:0]  repeat_period;
    logic [REG_W-1:0]  long_time;
    logic [REG_W-1:0]  lock_time;
  } cfg_t;

  // Controller -> datapath
  typedef struct packed {
    logic    en;
    cnt_op_t op;
    logic    cnt_clr;
    logic    set_act;
    logic    clr_act;
    logic    set_hold;
    logic    set_rep;
    logic    set_long;
    logic    clr_flags;
  } dp_cmd_t;

  // Datapath -> controller, compares on the stepped count plus the hold flag
  typedef struct packed {
    logic ge_confirm;
    logic step_zero;
    logic eq_hold;
    logic rep_hit;
    logic ge_long;
    logic ge_lock;
    logic hold_bit;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/bdhr_regs.sv =====
// ---------------------------------------------------------------------------
// bdhr_regs: APB configuration registers
// Five threshold registers, zero-wait writes and reads, plus a pulse that
// flags a new repeat period so the remainder can be rebuilt.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdhr_regs (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [bdhr_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [bdhr_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [bdhr_pkg::DATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready,
  output bdhr_pkg::cfg_t              cfg,
  output logic                        rep_wr
);
  import bdhr_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       rep_wr_r, rep_wr_nxt;
  logic       wr_en;
  logic [2:0] idx;

  assign cfg_pready = 1'b1;
  assign idx   = cfg_paddr[4:2];
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite;

  // Register writes
  always_comb begin
    cfg_nxt    = cfg_r;
    rep_wr_nxt = 1'b0;
    if (wr_en) begin
      case (idx)
        REG_CONFIRM: cfg_nxt.confirm       = cfg_pwdata[CONF_W-1:0];
        REG_HOLD:    cfg_nxt.hold_time     = cfg_pwdata[REG_W-1:0];
        REG_REPEAT: begin
          cfg_nxt.repeat_period = cfg_pwdata[REG_W-1:0];
          rep_wr_nxt            = 1'b1;
        end
        REG_LONG:    cfg_nxt.long_time     = cfg_pwdata[REG_W-1:0];
        REG_LOCK:    cfg_nxt.lock_time     = cfg_pwdata[REG_W-1:0];
        default:     cfg_nxt               = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.confirm       <= RST_CONFIRM;
      cfg_r.hold_time     <= RST_HOLD;
      cfg_r.repeat_period <= RST_REPEAT;
      cfg_r.long_time     <= RST_LONG;
      cfg_r.lock_time     <= RST_LOCK;
      rep_wr_r            <= 1'b0;
    end else begin
      cfg_r    <= cfg_nxt;
      rep_wr_r <= rep_wr_nxt;
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_CONFIRM: cfg_prdata = DATA_W'(cfg_r.confirm);
      REG_HOLD:    cfg_prdata = DATA_W'(cfg_r.hold_time);
      REG_REPEAT:  cfg_prdata = DATA_W'(cfg_r.repeat_period);
      REG_LONG:    cfg_prdata = DATA_W'(cfg_r.long_time);
      REG_LOCK:    cfg_prdata = DATA_W'(cfg_r.lock_time);
      default:     cfg_prdata = '0;
    endcase
  end

  assign cfg    = cfg_r;
  assign rep_wr = rep_wr_r;

endmodule

`default_nettype wire

// ===== design/bdhr_rem.sv =====
// ---------------------------------------------------------------------------
// bdhr_rem: iterative remainder unit
// Restoring division, one quotient bit per cycle; gives tick count modulo
// the repeat period after a new period is written.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdhr_rem (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [bdhr_pkg::CNT_W-1:0]  dividend,
  input  wire logic [bdhr_pkg::REG_W-1:0]  divisor,
  output logic                             busy,
  output logic                             done,
  output logic [bdhr_pkg::CNT_W-1:0]       rem
);
  import bdhr_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic [CNT_W-1:0]  dvd_r, dvd_nxt;
  logic [CMP_W-1:0]  rem_r, rem_nxt;
  logic [TR_W-1:0]   trial;
  logic [TR_W-1:0]   div_w;
  logic              fits;

  // One restoring step
  assign trial = {rem_r, dvd_r[CNT_W-1]};
  assign div_w = TR_W'(divisor);
  assign fits  = trial >= div_w;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    iter_nxt = iter_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      iter_nxt = ITER_W'(CNT_W);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt  = {dvd_r[CNT_W-2:0], 1'b0};
      rem_nxt  = fits ? CMP_W'(trial - div_w) : CMP_W'(trial);
      iter_nxt = iter_r - ITER_W'(1);
      if (iter_r == ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      iter_r <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r | done_r;
  assign done = done_r;
  assign rem  = rem_r[CNT_W-1:0];

endmodule

`default_nettype wire

// ===== design/bdhr_dp.sv =====
// ---------------------------------------------------------------------------
// bdhr_dp: datapath
// Saturating tick counter, running count modulo the repeat period, the
// threshold compares and the five flag bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdhr_dp (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire bdhr_pkg::cfg_t             cfg,
  input  wire bdhr_pkg::dp_cmd_t          cmd,
  input  wire logic                       rem_load,
  input  wire logic [bdhr_pkg::CNT_W-1:0] rem,
  output bdhr_pkg::dp_stat_t              stat,
  output logic [bdhr_pkg::CNT_W-1:0]      tick_count,
  output logic                            act_bit,
  output logic                            lock_bit,
  output logic                            hold_bit,
  output logic                            rep_bit,
  output logic                            long_bit
);
  import bdhr_pkg::*;

  logic [CNT_W-1:0] tick_r, tick_nxt;
  logic [CNT_W-1:0] repc_r, repc_nxt;
  logic             act_r, act_nxt;
  logic             lock_r, lock_nxt;
  logic             hold_r, hold_nxt;
  logic             rep_r, rep_nxt;
  logic             long_r, long_nxt;

  logic [CNT_W-1:0] step;
  logic [CNT_W-1:0] rstep;
  logic             sat;
  logic             wrap;
  logic [CMP_W-1:0] step_w;

  assign sat  = (tick_r == CNT_MAX);
  assign wrap = (TR_W'(repc_r) + TR_W'(1)) == TR_W'(cfg.repeat_period);

  // Stepped count and its value modulo the repeat period
  always_comb begin
    case (cmd.op)
      CNT_UP: begin
        step  = sat ? tick_r : tick_r + CNT_W'(1);
        rstep = sat ? repc_r : (wrap ? '0 : repc_r + CNT_W'(1));
      end
      CNT_DOWN: begin
        step  = (tick_r == '0) ? tick_r : tick_r - CNT_W'(1);
        rstep = repc_r;
      end
      CNT_CLR: begin
        step  = '0;
        rstep = '0;
      end
      default: begin
        step  = tick_r;
        rstep = repc_r;
      end
    endcase
  end

  // Compares for the controller
  assign step_w          = CMP_W'(step);
  assign stat.ge_confirm = step_w >= CMP_W'(cfg.confirm);
  assign stat.step_zero  = (step == '0);
  assign stat.eq_hold    = step_w == CMP_W'(cfg.hold_time);
  assign stat.rep_hit    = (cfg.repeat_period == '0) ? (step == '0) : (rstep == '0);
  assign stat.ge_long    = step_w >= CMP_W'(cfg.long_time);
  assign stat.ge_lock    = step_w >= CMP_W'(cfg.lock_time);
  assign stat.hold_bit   = hold_r;

  // State update
  always_comb begin
    tick_nxt = tick_r;
    repc_nxt = repc_r;
    act_nxt  = act_r;
    lock_nxt = lock_r;
    hold_nxt = hold_r;
    rep_nxt  = rep_r;
    long_nxt = long_r;
    if (cmd.en) begin
      tick_nxt = cmd.cnt_clr ? '0 : step;
      repc_nxt = cmd.cnt_clr ? '0 : rstep;
      if (cmd.set_act) begin
        act_nxt  = 1'b1;
        lock_nxt = 1'b1;
      end else if (cmd.clr_act) begin
        act_nxt  = 1'b0;
        lock_nxt = 1'b0;
      end
      if (cmd.clr_flags) begin
        hold_nxt = 1'b0;
        rep_nxt  = 1'b0;
        long_nxt = 1'b0;
      end else begin
        hold_nxt = hold_r | cmd.set_hold;
        rep_nxt  = rep_r  | cmd.set_rep;
        long_nxt = long_r | cmd.set_long;
      end
    end else if (rem_load) begin
      repc_nxt = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      repc_r <= '0;
      act_r  <= 1'b0;
      lock_r <= 1'b0;
      hold_r <= 1'b0;
      rep_r  <= 1'b0;
      long_r <= 1'b0;
    end else begin
      tick_r <= tick_nxt;
      repc_r <= repc_nxt;
      act_r  <= act_nxt;
      lock_r <= lock_nxt;
      hold_r <= hold_nxt;
      rep_r  <= rep_nxt;
      long_r <= long_nxt;
    end
  end

  assign tick_count = tick_r;
  assign act_bit    = act_r;
  assign lock_bit   = lock_r;
  assign hold_bit   = hold_r;
  assign rep_bit    = rep_r;
  assign long_bit   = long_r;

endmodule

`default_nettype wire

// ===== design/bdhr_ctrl.sv =====
// ---------------------------------------------------------------------------
// bdhr_ctrl: phase controller
// Idle / pushed / released state machine; picks the count step from the
// pin and issues flag and clear commands from the datapath compares.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdhr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               item_go,
  input  wire logic               pressed,
  input  wire bdhr_pkg::dp_stat_t stat,
  output bdhr_pkg::dp_cmd_t       cmd,
  output bdhr_pkg::phase_t        phase
);
  import bdhr_pkg::*;

  phase_t phase_r, phase_nxt;

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    if (item_go) begin
      case (phase_r)
        PH_IDLE:     if (stat.ge_confirm) phase_nxt = PH_PUSHED;
        PH_PUSHED:   if (!pressed) phase_nxt = PH_RELEASED;
        PH_RELEASED: if (stat.ge_lock) phase_nxt = PH_IDLE;
        default:     phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // Datapath commands
  always_comb begin
    cmd           = '0;
    cmd.en        = item_go;
    cmd.op        = CNT_KEEP;
    case (phase_r)
      PH_IDLE: begin
        cmd.op      = pressed ? CNT_UP : CNT_DOWN;
        cmd.set_act = stat.ge_confirm;
        cmd.cnt_clr = stat.ge_confirm;
        cmd.clr_act = !stat.ge_confirm && stat.step_zero;
      end
      PH_PUSHED: begin
        cmd.op       = pressed ? CNT_UP : CNT_CLR;
        cmd.set_hold = stat.eq_hold;
        cmd.set_rep  = (stat.hold_bit | stat.eq_hold) & stat.rep_hit;
        cmd.set_long = stat.ge_long;
      end
      PH_RELEASED: begin
        cmd.op        = pressed ? CNT_KEEP : CNT_UP;
        cmd.cnt_clr   = stat.ge_lock;
        cmd.clr_act   = stat.ge_lock;
        cmd.clr_flags = stat.ge_lock;
      end
      default: begin
        cmd.op = CNT_KEEP;
      end
    endcase
  end

  assign phase = phase_r;

endmodule

`default_nettype wire

// ===== design/button_debounce_hold_repeat.sv =====
// ---------------------------------------------------------------------------
// button_debounce_hold_repeat: debounced button with hold and auto repeat
// Each input request is one millisecond tick carrying the raw active-low
// pin (in_pin_level). Each accepted request yields exactly one result
// request: press, lock, hold, repeat and long-hold flags and the phase,
// as they stand after that tick.
// The result is registered, valid in the cycle after the input is accepted.
// Throughput: one tick per cycle while out_ready is high and no remainder
// rebuild runs; the output register holds the result and in_ready drops
// while it waits, so a stalled receiver stops the block without losing state.
// A write of repeat_period starts the remainder unit, which rebuilds the
// tick count modulo the new period one bit per cycle; in_ready is low from
// the write until the remainder is loaded. Other writes take effect at once.
// Reset (rst_n low, synchronous) returns to idle, clears the counter and
// all flags, drops out_valid and loads the register defaults
// (7, 300, 65, 2000, 30).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_hold_repeat (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // tick channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_pin_level,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_press_event,
  output logic                             out_locked,
  output logic                             out_hold_flag,
  output logic                             out_repeat_flag,
  output logic                             out_long_hold_flag,
  output logic [1:0]                       out_phase_out,
  // configuration
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [bdhr_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [bdhr_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [bdhr_pkg::DATA_W-1:0]      cfg_prdata,
  output logic                             cfg_pready
);
  import bdhr_pkg::*;

  cfg_t             cfg;
  dp_cmd_t          cmd;
  dp_stat_t         stat;
  phase_t           phase;
  logic             rep_wr;
  logic             rem_busy;
  logic             rem_done;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] tick_count;
  logic             in_acc;
  logic             out_valid_r, out_valid_nxt;

  bdhr_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg),
    .rep_wr      (rep_wr)
  );

  bdhr_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rep_wr),
    .dividend (tick_count),
    .divisor  (cfg.repeat_period),
    .busy     (rem_busy),
    .done     (rem_done),
    .rem      (rem)
  );

  bdhr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_go (in_acc),
    .pressed (!in_pin_level),
    .stat    (stat),
    .cmd     (cmd),
    .phase   (phase)
  );

  bdhr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .rem_load   (rem_done),
    .rem        (rem),
    .stat       (stat),
    .tick_count (tick_count),
    .act_bit    (out_press_event),
    .lock_bit   (out_locked),
    .hold_bit   (out_hold_flag),
    .rep_bit    (out_repeat_flag),
    .long_bit   (out_long_hold_flag)
  );

  // Handshake: phase, counter and flag state only move on an accepted tick, so
  // the state registers are the output payload.
  assign in_ready = (!out_valid_r || out_ready) && !rep_wr && !rem_busy;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_phase_out = phase;

  // Checks
  a_hold_needs_lock: assert property (@(posedge clk) disable iff (!rst_n)
    out_hold_flag |-> out_locked)
    else $error("hold flag set while unlocked");

  a_repeat_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_repeat_flag |-> out_hold_flag)
    else $error("repeat flag set without hold flag");

  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (phase == PH_IDLE) |-> !(out_hold_flag || out_long_hold_flag))
    else $error("hold flags left set in idle");

  a_pushed_locked: assert property (@(posedge clk) disable iff (!rst_n)
    (phase == PH_PUSHED) |-> out_locked)
    else $error("pushed phase without lock");

  a_state_moves_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> ($stable(out_phase_out) && $stable(out_hold_flag)
                 && $stable(out_press_event)))
    else $error("state changed without an accepted tick");

endmodule

`default_nettype wire
